/* hdl/rrqs_pkg.sv */
// Shared types, codes and defaults for the round-robin quantum scheduler.
// Depends on nothing; every other file of the block imports it.
package rrqs_pkg;

   // Default table depth and quantum after reset.
   localparam int DEF_MAX_TASKS = 16;
   localparam logic [15:0] QUANTUM_RESET = 16'd3;

   // Command codes.
   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_REMOVE  = 2'd1;
   localparam logic [1:0] CMD_SLICE   = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   // Status codes.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_ALL_DONE  = 2'd3;

   // One command transfer.
   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] task_id;
      logic [15:0] burst_time;
   } req_type;

   // One result transfer.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_id;
      logic [15:0] granted_time;
      logic        granted_finished;
   } rsp_type;

   // One table entry.
   typedef struct packed {
      logic [15:0] id;
      logic [15:0] remaining;
   } entry_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_RM_SCAN,
      S_RM_SHIFT,
      S_SL_SCAN
   } state_type;

endpackage

/* hdl/rrqs_table.sv */
// Task table memory: one write port and one read port with registered data.
// Depends on rrqs_pkg for the entry type.
module rrqs_table
   import rrqs_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data
);

   entry_type mem_ff [MAX_TASKS];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rrqs_ctrl.sv */
// Command sequencer: scans, compacts and updates the task table one entry a cycle.
// Depends on rrqs_pkg and drives the ports of rrqs_table.
module rrqs_ctrl
   import rrqs_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
   localparam int CW = $clog2(MAX_TASKS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_item,
   input  logic [15:0]   quantum_eff,
   output logic          rsp_valid,
   output rsp_type       rsp_item,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  entry_type     rd_data,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output entry_type     wr_data
);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [15:0]   id_ff, id_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic          id_match;
   logic          time_hit;
   logic          iss_more;
   logic [CW-1:0] chk_next;
   logic [15:0]   run_time;
   logic [15:0]   rem_after;
   logic [AW-1:0] ptr_adj;

   // Flags shared by the next-state and datapath blocks; chk_next, run_time and rem_after feed only the datapath.
   assign accept    = start && (state_ff == S_IDLE);
   assign id_match  = chk_vld_ff && (rd_data.id == id_ff);
   assign time_hit  = chk_vld_ff && (rd_data.remaining != 16'd0);
   assign iss_more  = iss_ff < count_ff;
   assign chk_next  = CW'(chk_idx_ff) + CW'(1);
   assign run_time  = (rd_data.remaining > quantum_eff) ? quantum_eff : rd_data.remaining;
   assign rem_after = rd_data.remaining - run_time;

   // Pointer after a removal keeps tracking the same task, wrapping at the end.
   always_comb begin
      ptr_adj = (pos_ff < ptr_ff) ? (ptr_ff - AW'(1)) : ptr_ff;
      if (CW'(ptr_adj) >= (count_ff - CW'(1))) begin
         ptr_adj = '0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_item.command == CMD_REMOVE)) begin
               state_in = S_RM_SCAN;
            end else if (accept && (req_item.command == CMD_SLICE)) begin
               state_in = S_SL_SCAN;
            end
         end
         S_RM_SCAN: begin
            if (id_match) begin
               state_in = S_RM_SHIFT;
            end else if (!iss_more) begin
               state_in = S_IDLE;
            end
         end
         S_RM_SHIFT: begin
            if (!iss_more) begin
               state_in = S_IDLE;
            end
         end
         S_SL_SCAN: begin
            if (time_hit || !iss_more) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and table controls.
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      iss_in       = iss_ff;
      addr_in      = addr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      pos_in       = pos_ff;
      id_in        = id_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: STAT_OK, granted_id: 16'd0, granted_time: 16'd0,
                       granted_finished: 1'b0};
      rd_en        = 1'b0;
      rd_addr      = iss_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = '{id: req_item.task_id, remaining: req_item.burst_time};
      case (state_ff)
         S_IDLE: begin
            iss_in  = '0;
            id_in   = req_item.task_id;
            addr_in = (CW'(ptr_ff) >= count_ff) ? '0 : ptr_ff;
            if (accept) begin
               case (req_item.command)
                  CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(MAX_TASKS)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_RESTART: begin
                     rsp_valid_in = 1'b1;
                     ptr_in       = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_RM_SCAN: begin
            if (id_match) begin
               pos_in = chk_idx_ff;
               iss_in = chk_next;
            end else if (iss_more) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[AW-1:0];
               iss_in     = iss_ff + CW'(1);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_NOT_FOUND;
            end
         end
         S_RM_SHIFT: begin
            // Each entry read last cycle moves down by one place.
            if (chk_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff - AW'(1);
               wr_data = rd_data;
            end
            if (iss_more) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[AW-1:0];
               iss_in     = iss_ff + CW'(1);
            end else begin
               count_in     = count_ff - CW'(1);
               ptr_in       = ptr_adj;
               rsp_valid_in = 1'b1;
            end
         end
         S_SL_SCAN: begin
            if (time_hit) begin
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff;
               wr_data = '{id: rd_data.id, remaining: rem_after};
               ptr_in  = (chk_next < count_ff) ? chk_next[AW-1:0] : '0;
               rsp_valid_in = 1'b1;
               rsp_in  = '{status: STAT_OK, granted_id: rd_data.id,
                           granted_time: run_time,
                           granted_finished: (rem_after == 16'd0)};
            end else if (iss_more) begin
               rd_en      = 1'b1;
               rd_addr    = addr_ff;
               chk_vld_in = 1'b1;
               chk_idx_in = addr_ff;
               addr_in    = ((CW'(addr_ff) + CW'(1)) < count_ff) ? (addr_ff + AW'(1)) : '0;
               iss_in     = iss_ff + CW'(1);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_ALL_DONE;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      iss_ff     <= iss_in;
      addr_ff    <= addr_in;
      chk_idx_ff <= chk_idx_in;
      pos_ff     <= pos_in;
      id_ff      <= id_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The fill count never passes the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS))
      else $error("task count above table depth");

   // The service pointer stays inside the filled part of the table, or at zero.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (CW'(ptr_ff) < count_ff) || (ptr_ff == '0))
      else $error("service pointer outside the table");

   // A result is only issued while the sequencer is idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result issued while busy");

   // A finished grant always ran for at least one time unit.
   a_finish_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.granted_finished) |-> (rsp_ff.granted_time != 16'd0))
      else $error("finished grant with zero run time");

endmodule

/* hdl/round_robin_quantum_scheduler.sv */
// Insert and restart answer in the cycle after the command transfer; a slice and a
// remove scan the table one entry per cycle through its single read port, and a
// remove then shifts the later entries down.
// One command at a time; busy holds the next transfer off while a slice or remove
// runs. The result strobe lasts one cycle; the receiver cannot stall.
// Synchronous reset clears the task count and the pointer and sets quantum to 3.
module round_robin_quantum_scheduler
   import rrqs_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   logic [15:0]   quantum_ff;
   logic [15:0]   quantum_in;
   logic [15:0]   quantum_eff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   // Quantum register; a transfer is taken whenever it is offered.
   assign csr_ready  = 1'b1;
   assign quantum_in = (csr_valid && csr_ready) ? csr_data : quantum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   // A zero quantum grants one unit.
   assign quantum_eff = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;

   rrqs_ctrl #(
      .MAX_TASKS(MAX_TASKS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .quantum_eff(quantum_eff),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   rrqs_table #(
      .MAX_TASKS(MAX_TASKS)
   ) u_table (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the round-robin quantum scheduler.
// Depends on rrqs_pkg and round_robin_quantum_scheduler; a scoreboard class predicts each result.
module tb
   import rrqs_pkg::*;
;

   localparam int TABLE_DEPTH = DEF_MAX_TASKS;
   localparam int PHASE_ITEMS = 238;
   // Worst case is far below this: 1453 commands with their sender gaps.
   localparam int RUN_LIMIT = 8_000_000;

   // Table model of the scheduler and the queue of results it still owes.
   class grant_ledger;
      logic [15:0] id_table [TABLE_DEPTH];
      logic [15:0] time_table [TABLE_DEPTH];
      int unsigned task_total;
      int unsigned next_slot;
      logic [15:0] quantum;
      rsp_type     due [$];
      int          mismatches;
      int          checked;

      function new();
         task_total = 0;
         next_slot  = 0;
         quantum    = QUANTUM_RESET;
         mismatches = 0;
         checked    = 0;
      endfunction

      // Apply one accepted command transfer and queue the result it must produce.
      function void log_command(req_type cmd);
         rsp_type     want;
         int unsigned pos;
         int unsigned idx;
         int unsigned q;
         int unsigned run;
         int unsigned left;
         bit          hit;
         want = '0;
         case (cmd.command)
            CMD_INSERT: begin
               if (task_total >= TABLE_DEPTH) begin
                  want.status = STAT_FULL;
               end else begin
                  id_table[task_total]   = cmd.task_id;
                  time_table[task_total] = cmd.burst_time;
                  task_total++;
                  want.status = STAT_OK;
               end
            end
            CMD_REMOVE: begin
               pos = task_total;
               for (int i = 0; i < task_total; i++) begin
                  if (id_table[i] == cmd.task_id) begin
                     pos = i;
                     break;
                  end
               end
               if (pos >= task_total) begin
                  want.status = STAT_NOT_FOUND;
               end else begin
                  // Close the gap and keep the pointer on the same task.
                  for (int i = pos; i + 1 < task_total; i++) begin
                     id_table[i]   = id_table[i + 1];
                     time_table[i] = time_table[i + 1];
                  end
                  task_total--;
                  if (pos < next_slot) next_slot--;
                  if (next_slot >= task_total) next_slot = 0;
                  want.status = STAT_OK;
               end
            end
            CMD_SLICE: begin
               idx = next_slot;
               q   = (quantum == 16'd0) ? 1 : quantum;
               hit = 1'b0;
               if (task_total == 0 || idx >= task_total) idx = 0;
               // Circular scan for the first task with time left.
               for (int k = 0; k < task_total; k++) begin
                  if (time_table[idx] != 16'd0) begin
                     left = time_table[idx];
                     run  = (left > q) ? q : left;
                     left = left - run;
                     time_table[idx] = left[15:0];
                     next_slot = (idx + 1 < task_total) ? idx + 1 : 0;
                     want.status           = STAT_OK;
                     want.granted_id       = id_table[idx];
                     want.granted_time     = run[15:0];
                     want.granted_finished = (left == 0);
                     hit = 1'b1;
                     break;
                  end
                  idx = (idx + 1 < task_total) ? idx + 1 : 0;
               end
               if (!hit) want.status = STAT_ALL_DONE;
            end
            default: begin
               next_slot   = 0;
               want.status = STAT_OK;
            end
         endcase
         due.push_back(want);
      endfunction

      // Compare one result transfer with the oldest expectation.
      function void check_grant(rsp_type got);
         rsp_type want;
         checked++;
         if (due.size() == 0) begin
            $error("result transfer with no command waiting: status %0d", got.status);
            mismatches++;
            return;
         end
         want = due.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.granted_id !== want.granted_id) begin
            $error("granted_id: expected %0h, actual %0h", want.granted_id, got.granted_id);
            mismatches++;
         end
         if (got.granted_time !== want.granted_time) begin
            $error("granted_time: expected %0h, actual %0h", want.granted_time,
                   got.granted_time);
            mismatches++;
         end
         if (got.granted_finished !== want.granted_finished) begin
            $error("granted_finished: expected %0b, actual %0b", want.granted_finished,
                   got.granted_finished);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [15:0] csr_data = '0;

   grant_ledger ledger;
   int          sent = 0;
   int          csr_writes = 0;

   round_robin_quantum_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Free-running clock, period 12.
   always #6 clock = ~clock;

   // Every result strobe is a transfer that must match the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) ledger.check_grant(rsp_item);
   end

   function automatic req_type make_req(logic [1:0] cmd, logic [15:0] id, logic [15:0] burst);
      req_type r;
      r.command    = cmd;
      r.task_id    = id;
      r.burst_time = burst;
      return r;
   endfunction

   // Mostly well-formed traffic: the command mix follows the table fill, and most
   // removes name an id that is present.
   function automatic req_type random_command();
      req_type     r;
      int unsigned fill;
      int unsigned ins_pct;
      int unsigned rem_pct;
      int unsigned pick;
      int unsigned roll;
      fill    = ledger.task_total;
      ins_pct = (fill >= TABLE_DEPTH) ? 10 : ((fill < 4) ? 50 : 30);
      rem_pct = (fill == 0) ? 5 : 20;
      r.task_id = ($urandom_range(99) < 70) ? 16'($urandom_range(15))
                                            : 16'($urandom_range(65535));
      roll = $urandom_range(99);
      if (roll < 10)      r.burst_time = 16'd0;
      else if (roll < 70) r.burst_time = 16'($urandom_range(12, 1));
      else                r.burst_time = 16'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < ins_pct) begin
         r.command = CMD_INSERT;
      end else if (pick < ins_pct + rem_pct) begin
         r.command = CMD_REMOVE;
         if (fill > 0 && $urandom_range(99) < 85)
            r.task_id = ledger.id_table[$urandom_range(fill - 1)];
      end else if (pick < ins_pct + rem_pct + 5) begin
         r.command = CMD_RESTART;
      end else begin
         r.command = CMD_SLICE;
      end
      return r;
   endfunction

   // Offer one command and hold it until the transfer happens; start stays high.
   task automatic issue_command(input req_type r);
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      ledger.log_command(r);
      sent++;
   endtask

   // Random sender gap before the next command.
   task automatic pause_sender(input int unsigned idle_pct);
      int n;
      n = 0;
      while ($urandom_range(99) < idle_pct && n < 40) n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected result has arrived.
   task automatic drain_results();
      start <= 1'b0;
      while (ledger.due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write the quantum register while the block is idle.
   task automatic write_quantum(input logic [15:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ledger.quantum = value;
      csr_writes++;
   endtask

   task automatic run_phase(input logic [15:0] q, input int unsigned idle_pct);
      drain_results();
      write_quantum(q);
      repeat (PHASE_ITEMS) begin
         pause_sender(idle_pct);
         issue_command(random_command());
      end
   endtask

   // Main sequence: reset, directed commands, then random phases.
   initial begin
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, unknown id and restart, at the reset quantum.
      issue_command(make_req(CMD_SLICE, 16'h0000, 16'h0000));
      issue_command(make_req(CMD_REMOVE, 16'h1234, 16'hFFFF));
      issue_command(make_req(CMD_RESTART, 16'hFFFF, 16'hFFFF));
      // Zero burst, extreme fields and a duplicate id.
      issue_command(make_req(CMD_INSERT, 16'h0000, 16'h0000));
      issue_command(make_req(CMD_INSERT, 16'hFFFF, 16'hFFFF));
      pause_sender(23);
      issue_command(make_req(CMD_INSERT, 16'h0007, 16'h0005));
      issue_command(make_req(CMD_INSERT, 16'h0007, 16'h0002));
      repeat (3) begin
         pause_sender(23);
         issue_command(make_req(CMD_SLICE, 16'h0000, 16'h0000));
      end
      // Fill the table, then one insert too many.
      for (int i = 0; i < TABLE_DEPTH - 4; i++) begin
         issue_command(make_req(CMD_INSERT, 16'(16'h0100 + i), 16'($urandom_range(6, 1))));
      end
      issue_command(make_req(CMD_INSERT, 16'hAAAA, 16'h5555));
      // Remove the first of two duplicates, then the head entry.
      issue_command(make_req(CMD_REMOVE, 16'h0007, 16'h0000));
      issue_command(make_req(CMD_REMOVE, 16'h0000, 16'h0000));

      // Random phases: zero and extreme quanta, then ordinary ones.
      run_phase(16'h0000, 23);
      run_phase(16'hFFFF, 23);
      run_phase(16'h0001, 50);
      run_phase(16'($urandom_range(9, 2)), 50);
      run_phase(16'($urandom_range(65535, 1)), 0);
      run_phase(16'h0004, 0);

      drain_results();
      repeat (40) @(posedge clock);
      if (ledger.due.size() != 0) ledger.mismatches++;

      $display("summary: %0d commands sent, %0d results compared, %0d quantum writes",
               sent, ledger.checked, csr_writes);
      $display("summary: quanta 3, 0, 65535, 1 and random; empty, full and drained tables");
      if (ledger.mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(RUN_LIMIT);
      $display("tb: errors");
      $finish;
   end

endmodule

/* filelist.f */
hdl/rrqs_pkg.sv
hdl/rrqs_table.sv
hdl/rrqs_ctrl.sv
hdl/round_robin_quantum_scheduler.sv
tb/tb.sv
